>>> design/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    `ASSERT_PROP(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_PROP(lbl, (ante) |=> (cons), msg)

`endif

>>> design/tre_pkg.sv
// Types and constants of the transparency RLE encoder.
// No dependencies.
`default_nettype none

package tre_pkg;

    localparam int OUT_ADDR_BITS = 24;
    localparam int VALUE_BITS    = 8;
    localparam int DIM_BITS      = 16;
    localparam int CAP_BITS      = 24;
    localparam int RUN_BITS      = 7;
    localparam int MAX_RESULTS   = 6;
    localparam int CNT_BITS      = 3;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CAPACITY     = 2'd2;

    localparam logic [RUN_BITS-1:0] RUN_MAX = 7'h7f;

    localparam logic [DIM_BITS-1:0] DIM_RESET = 16'd1;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 24'hffffff;

    typedef struct packed {
        logic [OUT_ADDR_BITS-1:0] address;
        logic [VALUE_BITS-1:0]    value;
        logic                     enable;
        logic                     done;
        logic [OUT_ADDR_BITS-1:0] total;
        logic                     status;
    } result_t;

endpackage

`default_nettype wire

>>> design/transparency_rle_encoder.sv
// Transparency RLE sprite encoder: pixels in, stream byte writes out.
// Depends on tre_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Takes one pixel per request and turns it into the byte writes it causes
// (0 to 6: header bytes on the first pixel of an image, a pixel byte for
// opaque pixels, count bytes when a run closes or fills). All writes of one
// pixel are worked out in the accept cycle and held in a six-entry result
// buffer that hands out one write per cycle while out_ready is high; the
// next pixel is accepted in the cycle the buffer's last write leaves, and
// a pixel causing no write leaves the buffer empty for the next pixel.
// The final write of an image carries stream_done, the stream length and
// the overflow status; the encoder then starts over. Configuration is
// taken every cycle on the cfg port and must only change between images.
module transparency_rle_encoder
    import tre_pkg::*;
#(
    parameter int ADDRESS_BITS = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CAP_BITS-1:0]      cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [VALUE_BITS-1:0]    pixel,
    input  wire logic                     transparent,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [OUT_ADDR_BITS-1:0]      write_address,
    output logic [VALUE_BITS-1:0]         write_value,
    output logic                          write_enable,
    output logic                          stream_done,
    output logic [OUT_ADDR_BITS-1:0]      total_length,
    output logic                          status
);

    localparam int CMP_BITS = (ADDRESS_BITS > CAP_BITS) ? ADDRESS_BITS : CAP_BITS;
    localparam logic [ADDRESS_BITS-1:0] ADDR_MAX = {ADDRESS_BITS{1'b1}};
    localparam logic [ADDRESS_BITS-1:0] SLOT_RESET = ADDRESS_BITS'(4);
    localparam logic [ADDRESS_BITS-1:0] NEXT_RESET = ADDRESS_BITS'(5);

    function automatic logic [ADDRESS_BITS-1:0] bump(input logic [ADDRESS_BITS-1:0] a);
        return (a == ADDR_MAX) ? a : a + 1'b1;
    endfunction

    function automatic result_t make_res(
        input logic [ADDRESS_BITS-1:0] a,
        input logic [VALUE_BITS-1:0]   v,
        input logic                    d,
        input logic                    ovf_in,
        input logic [ADDRESS_BITS-1:0] tot,
        input logic [CAP_BITS-1:0]     cap
    );
        result_t r;
        logic    en;
        en        = (CMP_BITS'(a) < CMP_BITS'(cap)) && (a != ADDR_MAX);
        r.address = OUT_ADDR_BITS'(a);
        r.value   = v;
        r.enable  = en;
        r.done    = d;
        r.total   = d ? OUT_ADDR_BITS'(tot) : '0;
        r.status  = d && (ovf_in || !en);
        return r;
    endfunction

    // configuration
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [CAP_BITS-1:0] cap_reg;

    // image state
    logic                    started_reg;
    logic                    rt_reg;
    logic [RUN_BITS-1:0]     rl_reg;
    logic [ADDRESS_BITS-1:0] cs_reg;
    logic [ADDRESS_BITS-1:0] na_reg;
    logic [DIM_BITS-1:0]     col_reg;
    logic [DIM_BITS-1:0]     row_reg;
    logic                    ovf_reg;

    // result buffer
    result_t             ent_reg [MAX_RESULTS];
    result_t             ent_next [MAX_RESULTS];
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] idx_reg;
    logic                bvalid_reg;

    // per-pixel working values
    logic                    rt_next;
    logic [RUN_BITS-1:0]     rl_next;
    logic [ADDRESS_BITS-1:0] cs_next;
    logic [ADDRESS_BITS-1:0] na_next;
    logic                    ovf_next;
    logic [CNT_BITS-1:0]     cnt_next;
    logic                    img_last;
    logic                    col_last;
    logic                    row_last;

    logic in_acc;
    logic out_acc;
    logic out_last;

    assign cfg_ready = 1'b1;
    assign out_valid = bvalid_reg;
    assign out_last  = (idx_reg == cnt_reg - 3'd1);
    assign in_ready  = !bvalid_reg || (out_ready && out_last);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    assign write_address = ent_reg[idx_reg].address;
    assign write_value   = ent_reg[idx_reg].value;
    assign write_enable  = ent_reg[idx_reg].enable;
    assign stream_done   = ent_reg[idx_reg].done;
    assign total_length  = ent_reg[idx_reg].total;
    assign status        = ent_reg[idx_reg].status;

    assign col_last = ({1'b0, col_reg} + 17'd1) >= {1'b0, width_reg};
    assign row_last = ({1'b0, row_reg} + 17'd1) >= {1'b0, height_reg};
    assign img_last = col_last && row_last;

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = '0;
        ovf_next = ovf_reg;
        rt_next  = rt_reg;
        rl_next  = rl_reg;
        cs_next  = cs_reg;
        na_next  = na_reg;

        // header: state already holds its reset values here
        if (!started_reg)
        begin
            ent_next[0] = make_res(ADDRESS_BITS'(0), width_reg[7:0], 1'b0, ovf_next, na_next,
                                   cap_reg);
            ent_next[1] = make_res(ADDRESS_BITS'(1), width_reg[15:8], 1'b0, ovf_next, na_next,
                                   cap_reg);
            ent_next[2] = make_res(ADDRESS_BITS'(2), height_reg[7:0], 1'b0, ovf_next, na_next,
                                   cap_reg);
            ent_next[3] = make_res(ADDRESS_BITS'(3), height_reg[15:8], 1'b0, ovf_next, na_next,
                                   cap_reg);
            ovf_next = ovf_next || !ent_next[0].enable || !ent_next[1].enable
                       || !ent_next[2].enable || !ent_next[3].enable;
            cnt_next = 3'd4;
            rt_next  = transparent;
        end

        if (transparent == rt_next)
        begin
            rl_next = rl_next + 1'b1;
            if (!transparent)
            begin
                ent_next[cnt_next] = make_res(na_next, pixel, 1'b0, ovf_next, na_next, cap_reg);
                ovf_next = ovf_next || !ent_next[cnt_next].enable;
                cnt_next = cnt_next + 1'b1;
                na_next  = bump(na_next);
            end
            // full run: close it now and open a fresh slot
            if (rl_next == RUN_MAX)
            begin
                ent_next[cnt_next] = make_res(cs_next, {transparent, RUN_MAX}, 1'b0, ovf_next,
                                              na_next, cap_reg);
                ovf_next = ovf_next || !ent_next[cnt_next].enable;
                cnt_next = cnt_next + 1'b1;
                rl_next  = '0;
                cs_next  = na_next;
                na_next  = bump(na_next);
            end
        end
        else
        begin
            ent_next[cnt_next] = make_res(cs_next, {rt_next, rl_next}, 1'b0, ovf_next, na_next,
                                          cap_reg);
            ovf_next = ovf_next || !ent_next[cnt_next].enable;
            cnt_next = cnt_next + 1'b1;
            rt_next  = transparent;
            rl_next  = RUN_BITS'(1);
            cs_next  = na_next;
            na_next  = bump(na_next);
            if (!transparent)
            begin
                ent_next[cnt_next] = make_res(na_next, pixel, 1'b0, ovf_next, na_next, cap_reg);
                ovf_next = ovf_next || !ent_next[cnt_next].enable;
                cnt_next = cnt_next + 1'b1;
                na_next  = bump(na_next);
            end
        end

        // flush the open run on the last pixel
        if (img_last)
        begin
            ent_next[cnt_next] = make_res(cs_next, {rt_next, rl_next}, 1'b1, ovf_next, na_next,
                                          cap_reg);
            ovf_next = ovf_next || !ent_next[cnt_next].enable;
            cnt_next = cnt_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            cap_reg    <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_CAPACITY:     cap_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            rt_reg      <= 1'b0;
            rl_reg      <= '0;
            cs_reg      <= SLOT_RESET;
            na_reg      <= NEXT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (in_acc)
        begin
            if (img_last)
            begin
                started_reg <= 1'b0;
                rt_reg      <= 1'b0;
                rl_reg      <= '0;
                cs_reg      <= SLOT_RESET;
                na_reg      <= NEXT_RESET;
                col_reg     <= '0;
                row_reg     <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                started_reg <= 1'b1;
                rt_reg      <= rt_next;
                rl_reg      <= rl_next;
                cs_reg      <= cs_next;
                na_reg      <= na_next;
                ovf_reg     <= ovf_next;
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end
        else if (in_acc)
        begin
            bvalid_reg <= (cnt_next != '0);
            cnt_reg    <= cnt_next;
            idx_reg    <= '0;
        end
        else if (out_acc)
        begin
            if (out_last)
                bvalid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            ent_reg <= ent_next;
    end

    `ASSERT_IMPL(a_buf_nonempty, bvalid_reg, cnt_reg != '0, "result buffer valid but empty")
    `ASSERT_IMPL(a_idx_in_range, bvalid_reg, idx_reg < cnt_reg, "result index past fill")
    `ASSERT_IMPL(a_done_is_last, out_valid && stream_done, out_last, "done not on last write")
    `ASSERT_NEXT(a_image_restart, in_acc && img_last, na_reg == NEXT_RESET, "image not restarted")

endmodule

`default_nettype wire

>>> sim/tb_transparency_rle_encoder.sv
// Testbench of transparency_rle_encoder: sends pixels and register writes and
// checks every stream byte write against a model of the sprite encoder.
// Depends on tre_pkg and the encoder RTL.
module tb_transparency_rle_encoder;
    import tre_pkg::*;

    localparam logic [OUT_ADDR_BITS-1:0] ADDR_SAT   = '1;
    localparam logic [OUT_ADDR_BITS-1:0] FIRST_SLOT = 24'd4;
    localparam int MAX_SHOWN     = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PIXELS = 200;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_PULSED} ready_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [CAP_BITS-1:0]      cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [VALUE_BITS-1:0]    pixel;
    logic                     transparent;
    logic                     out_valid;
    logic                     out_ready;
    logic [OUT_ADDR_BITS-1:0] write_address;
    logic [VALUE_BITS-1:0]    write_value;
    logic                     write_enable;
    logic                     stream_done;
    logic [OUT_ADDR_BITS-1:0] total_length;
    logic                     status;

    // encoder model state
    logic [DIM_BITS-1:0]      enc_width;
    logic [DIM_BITS-1:0]      enc_height;
    logic [CAP_BITS-1:0]      enc_capacity;
    logic                     in_image;
    logic                     open_transparent;
    logic [RUN_BITS-1:0]      open_count;
    logic [OUT_ADDR_BITS-1:0] slot_addr;
    logic [OUT_ADDR_BITS-1:0] write_ptr;
    logic [DIM_BITS-1:0]      col_pos;
    logic [DIM_BITS-1:0]      row_pos;
    logic                     dropped_any;

    result_t     pending_writes[$];
    result_t     seen_write;
    result_t     due_write;
    int          bad_writes;
    int          burst_left;
    int          ready_left;
    int          ready_tick;
    ready_mode_t ready_mode;

    transparency_rle_encoder #(
        .ADDRESS_BITS(OUT_ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel(pixel),
        .transparent(transparent),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .write_address(write_address),
        .write_value(write_value),
        .write_enable(write_enable),
        .stream_done(stream_done),
        .total_length(total_length),
        .status(status)
    );

    always #6 clk = ~clk;

    function automatic logic [OUT_ADDR_BITS-1:0] next_addr(input logic [OUT_ADDR_BITS-1:0] a);
        return (a == ADDR_SAT) ? a : a + 1'b1;
    endfunction

    function automatic void clear_image();
        in_image         = 1'b0;
        open_transparent = 1'b0;
        open_count       = '0;
        slot_addr        = FIRST_SLOT;
        write_ptr        = FIRST_SLOT + 1'b1;
        col_pos          = '0;
        row_pos          = '0;
        dropped_any      = 1'b0;
    endfunction

    function automatic void queue_write(input logic [OUT_ADDR_BITS-1:0] addr,
                                        input logic [VALUE_BITS-1:0] value,
                                        input logic done);
        result_t w;
        w.enable = (addr < enc_capacity) && (addr != ADDR_SAT);
        if (!w.enable)
            dropped_any = 1'b1;
        w.address = addr;
        w.value   = value;
        w.done    = done;
        w.total   = done ? write_ptr : '0;
        w.status  = done && dropped_any;
        pending_writes.push_back(w);
    endfunction

    function automatic void put_pixel_byte(input logic [VALUE_BITS-1:0] px);
        queue_write(write_ptr, px, 1'b0);
        write_ptr = next_addr(write_ptr);
    endfunction

    // Expected writes caused by one accepted pixel.
    function automatic void encode_pixel(input logic [VALUE_BITS-1:0] px, input logic tr);
        logic last_col;
        logic last_row;
        if (!in_image) begin
            queue_write(24'd0, enc_width[7:0], 1'b0);
            queue_write(24'd1, enc_width[15:8], 1'b0);
            queue_write(24'd2, enc_height[7:0], 1'b0);
            queue_write(24'd3, enc_height[15:8], 1'b0);
            in_image         = 1'b1;
            open_transparent = tr;
            open_count       = '0;
            slot_addr        = FIRST_SLOT;
            write_ptr        = FIRST_SLOT + 1'b1;
        end
        if (tr == open_transparent) begin
            open_count = open_count + 1'b1;
            if (!tr)
                put_pixel_byte(px);
            if (open_count == RUN_MAX) begin
                queue_write(slot_addr, {tr, RUN_MAX}, 1'b0);
                open_count = '0;
                slot_addr  = write_ptr;
                write_ptr  = next_addr(write_ptr);
            end
        end
        else begin
            queue_write(slot_addr, {open_transparent, open_count}, 1'b0);
            open_transparent = tr;
            open_count       = 7'd1;
            slot_addr        = write_ptr;
            write_ptr        = next_addr(write_ptr);
            if (!tr)
                put_pixel_byte(px);
        end
        // zero-sized registers behave like one
        last_col = ({1'b0, col_pos} + 17'd1) >= {1'b0, enc_width};
        last_row = ({1'b0, row_pos} + 17'd1) >= {1'b0, enc_height};
        if (last_col && last_row) begin
            queue_write(slot_addr, {open_transparent, open_count}, 1'b1);
            clear_image();
        end
        else if (last_col) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [CAP_BITS-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  enc_width    = data[DIM_BITS-1:0];
            CFG_IMAGE_HEIGHT: enc_height   = data[DIM_BITS-1:0];
            CFG_CAPACITY:     enc_capacity = data;
            default:          ;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [CAP_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // One pixel request; the sender may idle between bursts of random length.
    task automatic send_pixel(input logic [VALUE_BITS-1:0] px, input logic tr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        pixel       <= px;
        transparent <= tr;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_pixel(px, tr);
        @(negedge clk);
    endtask

    // Stop sending, wait for every outstanding write, then let the bench settle.
    task automatic drain_writes();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h00, 1'b1);
        drain_writes();
    endtask

    task automatic test_row_wrap();
        write_reg(CFG_IMAGE_WIDTH, 24'd3);
        write_reg(CFG_IMAGE_HEIGHT, 24'd2);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hff, 1'b1);
        send_pixel(8'haa, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'h0f, 1'b0);
        send_pixel(8'hf0, 1'b1);
        drain_writes();
    endtask

    task automatic test_capacity_limits();
        write_reg(CFG_CAPACITY, 24'd0);
        write_reg(CFG_IMAGE_WIDTH, 24'd2);
        write_reg(CFG_IMAGE_HEIGHT, 24'd1);
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h34, 1'b0);
        drain_writes();
        write_reg(CFG_CAPACITY, 24'd6);
        write_reg(CFG_IMAGE_WIDTH, 24'd4);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'h7f, 1'b0);
        drain_writes();
        write_reg(CFG_CAPACITY, CAP_RESET);
    endtask

    // Header carries the full size, then zero sizes end the image early.
    task automatic test_config_mid_image();
        write_reg(CFG_IMAGE_WIDTH, 24'h00ffff);
        write_reg(CFG_IMAGE_HEIGHT, 24'h00ffff);
        send_pixel(8'h3c, 1'b0);
        drain_writes();
        write_reg(CFG_IMAGE_WIDTH, 24'd0);
        write_reg(CFG_IMAGE_HEIGHT, 24'd0);
        send_pixel(8'hc3, 1'b0);
        drain_writes();
    endtask

    // Full runs of both kinds, each followed by a flag change on an empty run.
    task automatic test_long_runs();
        int i;
        write_reg(CFG_IMAGE_WIDTH, 24'd85);
        write_reg(CFG_IMAGE_HEIGHT, 24'd3);
        for (i = 0; i < RUN_MAX; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b1);
        for (i = 0; i < RUN_MAX; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
        send_pixel(8'($urandom_range(0, 255)), 1'b1);
        drain_writes();
    endtask

    task automatic test_random_images(input int target);
        int sent;
        int n_pix;
        int i;
        int run_left;
        int pick;
        logic tr;
        sent = 0;
        tr   = 1'b0;
        while (sent < target) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                drain_writes();
                if ($urandom_range(0, 1) == 1) begin
                    pick = $urandom_range(0, 9);
                    write_reg(CFG_IMAGE_WIDTH, (pick == 0) ? 24'd0 :
                              (pick == 1) ? 24'($urandom_range(9, 16)) :
                                            24'($urandom_range(1, 8)));
                end
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ? 24'd0 :
                              24'($urandom_range(1, 4)));
                if ($urandom_range(0, 1) == 1) begin
                    pick = $urandom_range(0, 19);
                    write_reg(CFG_CAPACITY, (pick < 5) ? 24'($urandom_range(0, 40)) :
                              (pick < 8) ? 24'($urandom) : CAP_RESET);
                end
            end
            n_pix = ((enc_width == 0) ? 1 : int'(enc_width)) *
                    ((enc_height == 0) ? 1 : int'(enc_height));
            run_left = 0;
            for (i = 0; i < n_pix; i++) begin
                if (run_left == 0) begin
                    tr       = ($urandom_range(0, 1) == 1);
                    run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12)
                                                           : $urandom_range(1, 6);
                end
                run_left--;
                send_pixel(8'($urandom_range(0, 255)), tr);
                if ($urandom_range(0, 60) == 0)
                    drain_writes();
            end
            sent += n_pix;
        end
        drain_writes();
    endtask

    // receiver stall pattern
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(10, 80);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            READY_HALF:   out_ready <= ($urandom_range(0, 1) != 0);
            default:      out_ready <= ((ready_tick % 5) < 2);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            seen_write.address = write_address;
            seen_write.value   = write_value;
            seen_write.enable  = write_enable;
            seen_write.done    = stream_done;
            seen_write.total   = total_length;
            seen_write.status  = status;
            if (pending_writes.size() == 0) begin
                bad_writes++;
                if (bad_writes <= MAX_SHOWN)
                    $display("unexpected write: addr %h value %h en %b done %b",
                             write_address, write_value, write_enable, stream_done);
            end
            else begin
                due_write = pending_writes.pop_front();
                if (seen_write !== due_write) begin
                    bad_writes++;
                    if (bad_writes <= MAX_SHOWN)
                        $display({"write mismatch: exp addr %h val %h en %b done %b len %h st %b",
                                  " / got addr %h val %h en %b done %b len %h st %b"},
                                 due_write.address, due_write.value, due_write.enable,
                                 due_write.done, due_write.total, due_write.status,
                                 seen_write.address, seen_write.value, seen_write.enable,
                                 seen_write.done, seen_write.total, seen_write.status);
                end
            end
        end
    end

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel        = '0;
        transparent  = 1'b0;
        out_ready    = 1'b0;
        bad_writes   = 0;
        burst_left   = 0;
        ready_left   = 0;
        ready_tick   = 0;
        enc_width    = DIM_RESET;
        enc_height   = DIM_RESET;
        enc_capacity = CAP_RESET;
        clear_image();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_row_wrap();
        test_capacity_limits();
        test_config_mid_image();
        test_long_runs();
        test_random_images(RANDOM_PIXELS);

        repeat (20) @(negedge clk);
        if (bad_writes == 0 && pending_writes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
